// File: sv/hlcd_pkg.sv
// ----------------------------------------------------------------------------
// hlcd_pkg: shared types and constants of the sync/length/checksum deframer
// Item formats between the scanner, the byte queue, the packer and the
// result queue, plus register indexes and frame constants.
// ----------------------------------------------------------------------------
package hlcd_pkg;

	localparam int BUFFER_BYTES_DEF = 512;
	localparam int QUEUE_DEPTH      = 4;

	// frame length L+4 tops out at 259, so nine bits cover any byte offset
	localparam int FLEN_W = 9;

	localparam logic [7:0]        SYNC_FIRST_RST  = 8'hAA;
	localparam logic [7:0]        SYNC_SECOND_RST = 8'hAB;
	localparam logic [FLEN_W-1:0] OFS_SYNC2       = 9'd1;
	localparam logic [FLEN_W-1:0] OFS_LEN         = 9'd3;
	localparam logic [FLEN_W-1:0] FLEN_ADD        = 9'd4;
	localparam logic [FLEN_W-1:0] FLEN_MIN        = 9'd6;

	localparam int         REG_IDX_W       = 1;
	localparam logic [0:0] REG_SYNC_FIRST  = 1'b0;
	localparam logic [0:0] REG_SYNC_SECOND = 1'b1;

	typedef enum logic [3:0] {
		S_HUNT_RD,
		S_HUNT_CHK,
		S_SYNC2_RD,
		S_SYNC2_CHK,
		S_LEN_RD,
		S_LEN_CHK,
		S_WAIT,
		S_SUM_RD,
		S_SUM_USE,
		S_EMIT_RD,
		S_EMIT_USE
	} scan_state_t;

	typedef struct packed {
		logic [7:0]  data;
		logic        first;
		logic        last;
		logic [31:0] good;
		logic [31:0] bad;
	} byte_item_t;

	typedef struct packed {
		logic [63:0] word;
		logic [3:0]  nbytes;
		logic        first;
		logic        last;
		logic [31:0] good;
		logic [31:0] bad;
	} word_item_t;

endpackage

// File: sv/hlcd_fifo.sv
// ----------------------------------------------------------------------------
// hlcd_fifo: small first-in first-out queue
// Register-file queue with full/empty flags; DEPTH must be a power of two.
// ----------------------------------------------------------------------------
module hlcd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = hlcd_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);
	localparam int AW = $clog2(DEPTH);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [AW:0]      wr_ptr_q;
	logic [AW:0]      rd_ptr_q;

	assign empty = (wr_ptr_q == rd_ptr_q);
	assign full  = (wr_ptr_q[AW] != rd_ptr_q[AW]) && (wr_ptr_q[AW-1:0] == rd_ptr_q[AW-1:0]);
	assign dout  = slot_q[rd_ptr_q[AW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (push && !full) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop && !empty) rd_ptr_q <= rd_ptr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) slot_q[wr_ptr_q[AW-1:0]] <= din;
	end

endmodule

// File: sv/hlcd_front.sv
// ----------------------------------------------------------------------------
// hlcd_front: byte buffer and frame scanner
// Stores received bytes in a circular buffer, hunts for the sync pair, waits
// for the whole frame, verifies the additive checksum and streams the bytes
// of good frames into the byte queue.
// ----------------------------------------------------------------------------
module hlcd_front #(
	parameter int BUFFER_BYTES = hlcd_pkg::BUFFER_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic [7:0]          in_byte,
	output logic                full,
	input  logic [7:0]          sync_first,
	input  logic [7:0]          sync_second,
	input  logic                bq_full,
	output logic                bq_push,
	output hlcd_pkg::byte_item_t bq_item
);
	localparam int AW = $clog2(BUFFER_BYTES);
	localparam int CW = $clog2(BUFFER_BYTES + 1);
	localparam int SW = AW + 1;
	localparam int FW = hlcd_pkg::FLEN_W;
	localparam logic [SW-1:0] NB = SW'(BUFFER_BYTES);

	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
		input logic [FW-1:0] ofs);
		logic [SW-1:0] s;
		s = {1'b0, base} + SW'(ofs);
		if (s >= NB) s = s - NB;
		return s[AW-1:0];
	endfunction

	logic [7:0]            byte_mem [BUFFER_BYTES];
	logic [7:0]            rd_data_q;
	logic [AW-1:0]         head_q;
	logic [AW-1:0]         tail_q;
	logic [CW-1:0]         count_q;
	logic [FW-1:0]         off_q;
	logic [FW-1:0]         flen_q;
	logic [7:0]            sum_q;
	logic [31:0]           good_q;
	logic [31:0]           bad_q;
	hlcd_pkg::scan_state_t state_q;
	hlcd_pkg::scan_state_t state_d;

	logic          accept;
	logic          rd_en;
	logic [FW-1:0] rd_ofs;
	logic [FW-1:0] drop;
	logic          good_inc;
	logic          bad_inc;
	logic [FW-1:0] last_ofs;
	logic          frame_in;
	logic          at_end;
	logic          is_last;

	assign full     = (count_q == CW'(BUFFER_BYTES));
	assign accept   = push && !full;
	assign last_ofs = flen_q - 1'b1;
	assign frame_in = (count_q >= CW'(flen_q));
	assign at_end   = (off_q == last_ofs);
	assign is_last  = at_end;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			hlcd_pkg::S_HUNT_RD: begin
				if (count_q != '0) state_d = hlcd_pkg::S_HUNT_CHK;
			end
			hlcd_pkg::S_HUNT_CHK: begin
				state_d = (rd_data_q == sync_first) ? hlcd_pkg::S_SYNC2_RD
					: hlcd_pkg::S_HUNT_RD;
			end
			hlcd_pkg::S_SYNC2_RD: begin
				if (count_q > CW'(hlcd_pkg::OFS_SYNC2)) state_d = hlcd_pkg::S_SYNC2_CHK;
			end
			hlcd_pkg::S_SYNC2_CHK: begin
				state_d = (rd_data_q == sync_second) ? hlcd_pkg::S_LEN_RD
					: hlcd_pkg::S_HUNT_RD;
			end
			hlcd_pkg::S_LEN_RD: begin
				if (count_q > CW'(hlcd_pkg::OFS_LEN)) state_d = hlcd_pkg::S_LEN_CHK;
			end
			hlcd_pkg::S_LEN_CHK: state_d = hlcd_pkg::S_WAIT;
			hlcd_pkg::S_WAIT: begin
				if (frame_in) begin
					state_d = (flen_q <= hlcd_pkg::FLEN_MIN) ? hlcd_pkg::S_HUNT_RD
						: hlcd_pkg::S_SUM_RD;
				end
			end
			hlcd_pkg::S_SUM_RD: state_d = hlcd_pkg::S_SUM_USE;
			hlcd_pkg::S_SUM_USE: begin
				if (!at_end) state_d = hlcd_pkg::S_SUM_RD;
				else if (rd_data_q == sum_q) state_d = hlcd_pkg::S_EMIT_RD;
				else state_d = hlcd_pkg::S_HUNT_RD;
			end
			hlcd_pkg::S_EMIT_RD: state_d = hlcd_pkg::S_EMIT_USE;
			hlcd_pkg::S_EMIT_USE: begin
				if (!bq_full) state_d = is_last ? hlcd_pkg::S_HUNT_RD : hlcd_pkg::S_EMIT_RD;
			end
			default: state_d = hlcd_pkg::S_HUNT_RD;
		endcase
	end

	// outputs of the scanner
	always_comb begin
		rd_en    = 1'b0;
		rd_ofs   = '0;
		drop     = '0;
		good_inc = 1'b0;
		bad_inc  = 1'b0;
		bq_push  = 1'b0;
		case (state_q)
			hlcd_pkg::S_HUNT_RD: rd_en = (count_q != '0);
			hlcd_pkg::S_HUNT_CHK: begin
				if (rd_data_q != sync_first) drop = FW'(1);
			end
			hlcd_pkg::S_SYNC2_RD: begin
				rd_en  = (count_q > CW'(hlcd_pkg::OFS_SYNC2));
				rd_ofs = hlcd_pkg::OFS_SYNC2;
			end
			hlcd_pkg::S_SYNC2_CHK: begin
				if (rd_data_q != sync_second) drop = FW'(1);
			end
			hlcd_pkg::S_LEN_RD: begin
				rd_en  = (count_q > CW'(hlcd_pkg::OFS_LEN));
				rd_ofs = hlcd_pkg::OFS_LEN;
			end
			hlcd_pkg::S_WAIT: begin
				// frame too short to carry a checksum: count it bad
				if (frame_in && flen_q <= hlcd_pkg::FLEN_MIN) begin
					drop    = FW'(1);
					bad_inc = 1'b1;
				end
			end
			hlcd_pkg::S_SUM_RD,
			hlcd_pkg::S_EMIT_RD: begin
				rd_en  = 1'b1;
				rd_ofs = off_q;
			end
			hlcd_pkg::S_SUM_USE: begin
				if (at_end) begin
					if (rd_data_q == sum_q) begin
						good_inc = 1'b1;
					end else begin
						bad_inc = 1'b1;
						drop    = FW'(1);
					end
				end
			end
			hlcd_pkg::S_EMIT_USE: begin
				bq_push = !bq_full;
				if (!bq_full && is_last) drop = flen_q;
			end
			default: begin
			end
		endcase
	end

	assign bq_item.data  = rd_data_q;
	assign bq_item.first = (off_q == '0);
	assign bq_item.last  = is_last;
	assign bq_item.good  = good_q;
	assign bq_item.bad   = bad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hlcd_pkg::S_HUNT_RD;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			good_q  <= '0;
			bad_q   <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= wrap_add(head_q, drop);
			if (accept) tail_q <= wrap_add(tail_q, FW'(1));
			count_q <= count_q + CW'(accept) - CW'(drop);
			if (good_inc) good_q <= good_q + 32'd1;
			if (bad_inc) bad_q <= bad_q + 32'd1;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			hlcd_pkg::S_LEN_CHK: flen_q <= FW'(rd_data_q) + hlcd_pkg::FLEN_ADD;
			hlcd_pkg::S_WAIT: begin
				off_q <= hlcd_pkg::OFS_LEN;
				sum_q <= '0;
			end
			hlcd_pkg::S_SUM_USE: begin
				if (!at_end) begin
					sum_q <= sum_q + rd_data_q;
					off_q <= off_q + 1'b1;
				end else begin
					off_q <= '0;
				end
			end
			hlcd_pkg::S_EMIT_USE: begin
				if (!bq_full) off_q <= off_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) byte_mem[tail_q] <= in_byte;
	end

	always_ff @(posedge clk) begin
		if (rd_en) rd_data_q <= byte_mem[wrap_add(head_q, rd_ofs)];
	end

endmodule

// File: sv/hlcd_pack.sv
// ----------------------------------------------------------------------------
// hlcd_pack: frame byte to word packer
// Collects frame bytes into words of up to eight bytes, earliest byte in the
// low lane, and hands each finished word to the result queue.
// ----------------------------------------------------------------------------
module hlcd_pack (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 bq_empty,
	input  hlcd_pkg::byte_item_t bq_item,
	output logic                 bq_pop,
	input  logic                 of_full,
	output logic                 of_push,
	output hlcd_pkg::word_item_t of_item
);
	logic [63:0] acc_word_q;
	logic [2:0]  acc_cnt_q;
	logic        acc_first_q;
	logic [63:0] new_word;
	logic        new_first;
	logic        done;

	always_comb begin
		for (int b = 0; b < 8; b++) begin
			if (3'(b) < acc_cnt_q) new_word[8*b +: 8] = acc_word_q[8*b +: 8];
			else if (3'(b) == acc_cnt_q) new_word[8*b +: 8] = bq_item.data;
			else new_word[8*b +: 8] = 8'd0;
		end
	end

	assign new_first = (acc_cnt_q == 3'd0) ? bq_item.first : acc_first_q;
	assign done      = bq_item.last || (acc_cnt_q == 3'd7);
	// hold the byte while a finished word cannot be handed on
	assign bq_pop    = !bq_empty && (!done || !of_full);
	assign of_push   = bq_pop && done;

	assign of_item.word   = new_word;
	assign of_item.nbytes = {1'b0, acc_cnt_q} + 4'd1;
	assign of_item.first  = new_first;
	assign of_item.last   = bq_item.last;
	assign of_item.good   = bq_item.good;
	assign of_item.bad    = bq_item.bad;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_cnt_q <= '0;
		end else if (bq_pop) begin
			acc_cnt_q <= done ? 3'd0 : acc_cnt_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (bq_pop && !done) begin
			acc_word_q  <= new_word;
			acc_first_q <= new_first;
		end
	end

endmodule

// File: sv/header_length_checksum_deframer_unit.sv
// Flow: once a frame's last byte is taken, the scanner sums the frame, then
//   copies its bytes through the byte queue and packer to the result queue.
// Each buffer read has a read state and a use state. Hunting for sync reads
//   each byte once; a good frame is read in a checksum pass, then a copy pass;
//   a bad checksum drops only the first byte, so the rest of the frame is rescanned.
// Reset: clears pointers, counts and queues, loads sync 0xAA/0xAB; buffer kept.
// ----------------------------------------------------------------------------
// header_length_checksum_deframer_unit: sync/length/checksum deframer
// Byte stream in, frame words out, with running good and bad frame counts.
// ----------------------------------------------------------------------------
module header_length_checksum_deframer_unit #(
	parameter int BUFFER_BYTES = hlcd_pkg::BUFFER_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [7:0]                    in_byte,
	output logic                          empty,
	input  logic                          pop,
	output logic [63:0]                   frame_word,
	output logic [3:0]                    word_bytes,
	output logic                          first_word,
	output logic                          last_word,
	output logic [31:0]                   good_total,
	output logic [31:0]                   bad_total,
	input  logic                          wr_en,
	input  logic [hlcd_pkg::REG_IDX_W-1:0] wr_index,
	input  logic [7:0]                    wr_data
);
	localparam int BW = $bits(hlcd_pkg::byte_item_t);
	localparam int WW = $bits(hlcd_pkg::word_item_t);

	logic [7:0] sync_first_q;
	logic [7:0] sync_second_q;

	logic                 bq_push;
	logic                 bq_full;
	logic                 bq_pop;
	logic                 bq_empty;
	hlcd_pkg::byte_item_t bq_in;
	hlcd_pkg::byte_item_t bq_out;
	logic [BW-1:0]        bq_dout;
	logic                 of_push;
	logic                 of_full;
	hlcd_pkg::word_item_t of_in;
	hlcd_pkg::word_item_t of_out;
	logic [WW-1:0]        of_dout;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= hlcd_pkg::SYNC_FIRST_RST;
			sync_second_q <= hlcd_pkg::SYNC_SECOND_RST;
		end else if (wr_en) begin
			case (wr_index)
				hlcd_pkg::REG_SYNC_FIRST:  sync_first_q  <= wr_data;
				hlcd_pkg::REG_SYNC_SECOND: sync_second_q <= wr_data;
				default: begin
				end
			endcase
		end
	end

	hlcd_front #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.in_byte    (in_byte),
		.full       (full),
		.sync_first (sync_first_q),
		.sync_second(sync_second_q),
		.bq_full    (bq_full),
		.bq_push    (bq_push),
		.bq_item    (bq_in)
	);

	hlcd_fifo #(
		.WIDTH(BW),
		.DEPTH(hlcd_pkg::QUEUE_DEPTH)
	) u_byte_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (bq_push),
		.din   (bq_in),
		.full  (bq_full),
		.pop   (bq_pop),
		.dout  (bq_dout),
		.empty (bq_empty)
	);

	assign bq_out = bq_dout;

	hlcd_pack u_pack (
		.clk     (clk),
		.arst_n  (arst_n),
		.bq_empty(bq_empty),
		.bq_item (bq_out),
		.bq_pop  (bq_pop),
		.of_full (of_full),
		.of_push (of_push),
		.of_item (of_in)
	);

	hlcd_fifo #(
		.WIDTH(WW),
		.DEPTH(hlcd_pkg::QUEUE_DEPTH)
	) u_word_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (of_push),
		.din   (of_in),
		.full  (of_full),
		.pop   (pop),
		.dout  (of_dout),
		.empty (empty)
	);

	assign of_out     = of_dout;
	assign frame_word = of_out.word;
	assign word_bytes = of_out.nbytes;
	assign first_word = of_out.first;
	assign last_word  = of_out.last;
	assign good_total = of_out.good;
	assign bad_total  = of_out.bad;

endmodule

// File: sv/hlcd_checker.sv
// ----------------------------------------------------------------------------
// hlcd_checker: port-level checks of the deframer
// Watches the result side for word framing and counter consistency.
// ----------------------------------------------------------------------------
module hlcd_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          push,
	input logic                          full,
	input logic [7:0]                    in_byte,
	input logic                          empty,
	input logic                          pop,
	input logic [63:0]                   frame_word,
	input logic [3:0]                    word_bytes,
	input logic                          first_word,
	input logic                          last_word,
	input logic [31:0]                   good_total,
	input logic [31:0]                   bad_total,
	input logic                          wr_en,
	input logic [hlcd_pkg::REG_IDX_W-1:0] wr_index,
	input logic [7:0]                    wr_data
);
	// a waiting result holds until it is transferred
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(frame_word) && $stable(word_bytes))
		else $error("result changed while waiting");

	a_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> word_bytes >= 4'd1 && word_bytes <= 4'd8)
		else $error("word byte count out of range");

	a_full_word: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !last_word |-> word_bytes == 4'd8)
		else $error("short word before end of frame");

	// after the last word of a frame, the next word opens a new frame
	a_next_frame: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && pop && last_word |=> empty || (first_word &&
		good_total == $past(good_total) + 32'd1))
		else $error("frame boundary broken");

endmodule

bind header_length_checksum_deframer_unit hlcd_checker u_hlcd_checker (.*);
